[hw/rtl/rtn_pkg.sv]
// Shared types, constants and letter tables for the Roman numeral converter.
// Used by rtn_front, rtn_queue, rtn_back and the top level; depends on nothing.
package rtn_pkg;

  // Field widths of the ports.
  localparam int unsigned ValueW = 14;
  localparam int unsigned CharW  = 7;

  // Widths inside the datapath.
  localparam int unsigned DigitW = 4;
  localparam int unsigned CountW = 4;
  localparam int unsigned PosW   = 2;

  // Register stages in the digit splitter.
  localparam int unsigned PipeStages = 6;

  // Most letters one value can produce.
  localparam logic [CountW-1:0] MaxLetters = 4'd15;

  // Reciprocals for exact division by 1000, 100 and 10 (multiply, then shift).
  localparam logic [14:0] Recip1000 = 15'd16778;  // 2^24 / 1000, rounded up
  localparam logic [10:0] Recip100  = 11'd1311;   // 2^17 / 100, rounded up
  localparam logic [7:0]  Recip10   = 8'd205;     // 2^11 / 10, rounded up

  // ASCII codes of the letters.
  localparam logic [CharW-1:0] CharM = 7'h4D;
  localparam logic [CharW-1:0] CharD = 7'h44;
  localparam logic [CharW-1:0] CharC = 7'h43;
  localparam logic [CharW-1:0] CharL = 7'h4C;
  localparam logic [CharW-1:0] CharX = 7'h58;
  localparam logic [CharW-1:0] CharV = 7'h56;
  localparam logic [CharW-1:0] CharI = 7'h49;

  // Decimal places, from the leading one down to the units.
  typedef enum logic [1:0] {
    PLACE_THOU  = 2'd0,
    PLACE_HUND  = 2'd1,
    PLACE_TENS  = 2'd2,
    PLACE_UNITS = 2'd3
  } place_e;

  // Letter column within a place: one-unit, five or ten letter.
  typedef enum logic [1:0] {
    COL_ONE  = 2'd0,
    COL_FIVE = 2'd1,
    COL_TEN  = 2'd2
  } col_e;

  // One classified value as it waits in the queue.
  typedef struct packed {
    logic [CountW-1:0] total;
    logic [1:0]        thou;
    logic [DigitW-1:0] hund;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] units;
  } desc_t;

  // Number of letters a decimal digit takes.
  function automatic logic [2:0] digit_len(logic [DigitW-1:0] d);
    logic [2:0] n;
    case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Column of the letter at a position within a digit's pattern.
  function automatic col_e digit_col(logic [DigitW-1:0] d, logic [PosW-1:0] pos);
    col_e c;
    case (d)
      4'd4:                   c = (pos == '0) ? COL_ONE : COL_FIVE;
      4'd9:                   c = (pos == '0) ? COL_ONE : COL_TEN;
      4'd5, 4'd6, 4'd7, 4'd8: c = (pos == '0) ? COL_FIVE : COL_ONE;
      default:                c = COL_ONE;
    endcase
    return c;
  endfunction

  // Letter for a place and column.
  function automatic logic [CharW-1:0] place_letter(place_e p, col_e c);
    logic [CharW-1:0] ch;
    case (p)
      PLACE_HUND: begin
        case (c)
          COL_FIVE: ch = CharD;
          COL_TEN:  ch = CharM;
          default:  ch = CharC;
        endcase
      end
      PLACE_TENS: begin
        case (c)
          COL_FIVE: ch = CharL;
          COL_TEN:  ch = CharC;
          default:  ch = CharX;
        endcase
      end
      PLACE_UNITS: begin
        case (c)
          COL_FIVE: ch = CharV;
          COL_TEN:  ch = CharX;
          default:  ch = CharI;
        endcase
      end
      default: ch = CharM;
    endcase
    return ch;
  endfunction

  // Letters emitted by one place of a classified value.
  function automatic logic [2:0] place_len(desc_t d, place_e p);
    logic [2:0] n;
    case (p)
      PLACE_HUND:  n = digit_len(d.hund);
      PLACE_TENS:  n = digit_len(d.tens);
      PLACE_UNITS: n = digit_len(d.units);
      default:     n = {1'b0, d.thou};
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/rtn_front.sv]
// Front end: accepts values, splits them into decimal digits and classifies them.
// Depends on rtn_pkg. Feeds rtn_queue and throttles input by the queue's free space.
module rtn_front #(
  parameter int unsigned QueueDepth = 8,
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [rtn_pkg::ValueW-1:0] value_i,
  input  logic [CntW-1:0]            q_count_i,
  output logic                       push_o,
  output rtn_pkg::desc_t             desc_o
);

  localparam int unsigned UsedW = $clog2(QueueDepth + rtn_pkg::PipeStages + 1);

  logic [rtn_pkg::PipeStages-1:0] vld_q, vld_d;
  logic [UsedW-1:0]               used;
  logic                           accept;

  logic [13:0] s0_v_q;
  logic [13:0] s1_v_q;
  logic [4:0]  s1_thou_q, s2_thou_q, s3_thou_q, s4_thou_q, s5_thou_q;
  logic [9:0]  s2_rem_q, s3_rem_q;
  logic [3:0]  s3_hund_q, s4_hund_q, s5_hund_q;
  logic [6:0]  s4_tu_q, s5_tu_q;
  logic [3:0]  s5_tens_q;

  logic [28:0] prod1;
  logic [4:0]  thou1;
  logic [13:0] diff2;
  logic [20:0] prod3;
  logic [9:0]  diff4;
  logic [14:0] prod5;
  logic [6:0]  diff6;
  logic [3:0]  units6;
  logic [1:0]  thou_cnt;
  logic [rtn_pkg::CountW-1:0] total;

  // Every word in flight holds a queue slot, so the pipeline never has to stall.
  assign used    = UsedW'($countones(vld_q)) + UsedW'(q_count_i);
  assign stall_o = (used >= UsedW'(QueueDepth));
  assign accept  = valid_i && !stall_o;
  assign vld_d   = {vld_q[rtn_pkg::PipeStages-2:0], accept};

  // Valid bits advance every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Thousands: exact quotient by reciprocal multiply.
  assign prod1 = 29'(s0_v_q) * 29'(rtn_pkg::Recip1000);
  assign thou1 = prod1[28:24];

  // Remainder below 1000.
  assign diff2 = s1_v_q - (14'(s1_thou_q) * 14'd1000);

  // Hundreds digit.
  assign prod3 = 21'(s2_rem_q) * 21'(rtn_pkg::Recip100);

  // Tens and units together, below 100.
  assign diff4 = s3_rem_q - (10'(s3_hund_q) * 10'd100);

  // Tens digit.
  assign prod5 = 15'(s4_tu_q) * 15'(rtn_pkg::Recip10);

  // Units digit.
  assign diff6  = s5_tu_q - (7'(s5_tens_q) * 7'd10);
  assign units6 = diff6[3:0];

  // Digit stages; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_v_q <= value_i;
    end
    s1_v_q    <= s0_v_q;
    s1_thou_q <= thou1;
    s2_thou_q <= s1_thou_q;
    s2_rem_q  <= diff2[9:0];
    s3_thou_q <= s2_thou_q;
    s3_rem_q  <= s2_rem_q;
    s3_hund_q <= prod3[20:17];
    s4_thou_q <= s3_thou_q;
    s4_hund_q <= s3_hund_q;
    s4_tu_q   <= diff4[6:0];
    s5_thou_q <= s4_thou_q;
    s5_hund_q <= s4_hund_q;
    s5_tu_q   <= s4_tu_q;
    s5_tens_q <= prod5[14:11];
  end

  // Classify: only thousands of one to three give letters.
  assign thou_cnt = ((s5_thou_q >= 5'd1) && (s5_thou_q <= 5'd3)) ? s5_thou_q[1:0] : 2'd0;
  assign total    = rtn_pkg::CountW'(thou_cnt)
                  + rtn_pkg::CountW'(rtn_pkg::digit_len(s5_hund_q))
                  + rtn_pkg::CountW'(rtn_pkg::digit_len(s5_tens_q))
                  + rtn_pkg::CountW'(rtn_pkg::digit_len(units6));

  // A value with no letters is dropped here.
  assign push_o       = vld_q[rtn_pkg::PipeStages-1] && (total != '0);
  assign desc_o.total = total;
  assign desc_o.thou  = thou_cnt;
  assign desc_o.hund  = s5_hund_q;
  assign desc_o.tens  = s5_tens_q;
  assign desc_o.units = units6;

endmodule

[hw/rtl/rtn_queue.sv]
// Short queue of classified words between the front end and the letter sequencer.
// Depends on rtn_pkg for the word type.
module rtn_queue #(
  parameter int unsigned QueueDepth = 8,
  localparam int unsigned CntW = $clog2(QueueDepth + 1),
  localparam int unsigned PtrW = $clog2(QueueDepth)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rtn_pkg::desc_t push_desc_i,
  input  logic           pop_i,
  output logic           valid_o,
  output rtn_pkg::desc_t desc_o,
  output logic [CntW-1:0] count_o
);

  rtn_pkg::desc_t  mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Pointers wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

[hw/rtl/rtn_back.sv]
// Back end: walks one classified word place by place and emits one letter per cycle
// unless stalled. Depends on rtn_pkg; takes words from rtn_queue and drives the output register.
module rtn_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  rtn_pkg::desc_t            q_desc_i,
  output logic                      q_pop_o,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [rtn_pkg::CharW-1:0] character_o,
  output logic                      last_o
);

  // First place at or after a start index that emits any letter.
  function automatic rtn_pkg::place_e next_place(rtn_pkg::desc_t d, logic [2:0] from);
    rtn_pkg::place_e r;
    r = rtn_pkg::PLACE_UNITS;
    for (int i = 3; i >= 0; i--) begin
      if ((3'(i) >= from) && (rtn_pkg::place_len(d, rtn_pkg::place_e'(2'(i))) != '0)) begin
        r = rtn_pkg::place_e'(2'(i));
      end
    end
    return r;
  endfunction

  logic                       busy_q, busy_d;
  rtn_pkg::desc_t             desc_q, desc_d;
  rtn_pkg::place_e            place_q, place_d;
  logic [rtn_pkg::PosW-1:0]   pos_q, pos_d;
  logic [rtn_pkg::CountW-1:0] cnt_q, cnt_d;

  logic                       out_valid_q, out_valid_d;
  logic [rtn_pkg::CharW-1:0]  char_q, char_d;
  logic                       last_q, last_d;

  logic                       adv, emit, load, cur_last;
  logic [rtn_pkg::DigitW-1:0] cur_digit;
  logic [rtn_pkg::CharW-1:0]  cur_char;

  // The output register moves when it is empty or being taken.
  assign adv  = !out_valid_q || !stall_i;
  assign emit = busy_q && adv;

  // Current letter.
  always_comb begin
    case (place_q)
      rtn_pkg::PLACE_HUND:  cur_digit = desc_q.hund;
      rtn_pkg::PLACE_TENS:  cur_digit = desc_q.tens;
      rtn_pkg::PLACE_UNITS: cur_digit = desc_q.units;
      default:              cur_digit = '0;
    endcase
    cur_char = rtn_pkg::place_letter(place_q, rtn_pkg::digit_col(cur_digit, pos_q));
  end

  assign cur_last = (cnt_q == (desc_q.total - 1'b1));
  assign load     = q_valid_i && (!busy_q || (emit && cur_last));
  assign q_pop_o  = load;

  // Sequencer: load a new word as the last letter of the old one leaves.
  always_comb begin
    busy_d  = busy_q;
    desc_d  = desc_q;
    place_d = place_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    if (load) begin
      busy_d  = 1'b1;
      desc_d  = q_desc_i;
      place_d = next_place(q_desc_i, 3'd0);
      pos_d   = '0;
      cnt_d   = '0;
    end else if (emit) begin
      if (cur_last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if ((3'(pos_q) + 3'd1) < rtn_pkg::place_len(desc_q, place_q)) begin
          pos_d = pos_q + 1'b1;
        end else begin
          pos_d   = '0;
          place_d = next_place(desc_q, 3'(place_q) + 3'd1);
        end
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = busy_q;
      char_d      = cur_char;
      last_d      = cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      place_q     <= rtn_pkg::PLACE_THOU;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      place_q     <= place_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign valid_o     = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

[hw/rtl/binary_to_roman_numeral.sv]
// An accepted value passes the six splitter stages, the queue, the sequencer's word register
// and the output register; its letters follow one per cycle unless stalled, the last one marked.
// The sequencer gives one letter per cycle unless the output stalls; a value has 1 to 15
// letters, and values with no letters give no output.
// Input accepts one word per cycle while the queue plus the six-stage splitter have room.
// Reset (rst_ni low, asynchronous) empties the splitter, the queue and the output.
module binary_to_roman_numeral #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [rtn_pkg::ValueW-1:0] value_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [rtn_pkg::CharW-1:0] character_o,
  output logic                      last_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            push, pop, q_valid;
  rtn_pkg::desc_t  push_desc, q_desc;
  logic [CntW-1:0] q_count;

  // Digit splitter and classifier.
  rtn_front #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .value_i  (value_i),
    .q_count_i(q_count),
    .push_o   (push),
    .desc_o   (push_desc)
  );

  // Queue between the two halves.
  rtn_queue #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_desc_i(push_desc),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .desc_o     (q_desc),
    .count_o    (q_count)
  );

  // Letter sequencer.
  rtn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_desc_i   (q_desc),
    .q_pop_o    (pop),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

[hw/rtl/rtn_checker.sv]
// Port-level checks for binary_to_roman_numeral, attached by the bind below.
// Depends on rtn_pkg for the letter codes and the letter limit.
module rtn_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      valid_o,
  input logic                      stall_i,
  input logic [rtn_pkg::CharW-1:0] character_o,
  input logic                      last_o
);

  logic [rtn_pkg::CountW-1:0] run_q;

  // Letters delivered so far in the current numeral.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (valid_o && !stall_i) begin
      run_q <= last_o ? '0 : run_q + 1'b1;
    end
  end

  // A stalled word stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output word withdrawn while stalled");

  // A stalled word keeps its contents.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(character_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // Only Roman letters leave the block.
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (character_o == rtn_pkg::CharM) || (character_o == rtn_pkg::CharD) ||
                (character_o == rtn_pkg::CharC) || (character_o == rtn_pkg::CharL) ||
                (character_o == rtn_pkg::CharX) || (character_o == rtn_pkg::CharV) ||
                (character_o == rtn_pkg::CharI))
    else $error("character is not a Roman letter");

  // No numeral runs past fifteen letters without a last mark.
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (run_q < rtn_pkg::MaxLetters) &&
                ((run_q != (rtn_pkg::MaxLetters - 1'b1)) || last_o))
    else $error("numeral longer than fifteen letters");

endmodule

bind binary_to_roman_numeral rtn_checker u_rtn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_o    (valid_o),
  .stall_i    (stall_i),
  .character_o(character_o),
  .last_o     (last_o)
);
